// File: rtl/mkcr_pkg.sv
package mkcr_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = $clog2(CHANNELS);

  // message kinds (upper nibble of the status byte)
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;
  localparam logic [3:0] KIND_PROG     = 4'hC;
  localparam logic [7:0] STATUS_SYSTEM = 8'hF0;

  localparam logic [6:0] CC_BANK_MSB = 7'd0;
  localparam logic [6:0] CC_BANK_LSB = 7'd32;

  localparam logic [4:0] DRUM_CHANNEL = 5'd10;
  localparam logic [6:0] NOTE_MAX     = 7'd127;
  localparam logic [5:0] SHIFT_UP     = 6'd48;
  localparam logic [6:0] PROG_UPPER   = 7'd64;

  // channel select keys beyond the 16 channels
  localparam logic [4:0] SEL_SHIFT_ONLY  = 5'd17;
  localparam logic [4:0] SEL_REMAP_ONLY  = 5'd18;
  localparam logic [4:0] SEL_REMAP_SHIFT = 5'd19;

  // configuration register indexes
  localparam logic REG_MASTER_CHANNEL = 1'b0;
  localparam logic REG_FIRST_KEY      = 1'b1;

  localparam logic [4:0] MASTER_RST = 5'd1;
  localparam logic [6:0] FIRST_KEY_RST = 7'd21;
  localparam logic [4:0] TARGET_RST = 5'd1;

endpackage

// File: rtl/midi_keyswitch_channel_router_unit.sv
// Keyswitch channel router for MIDI channel messages.
// Input channel: in_valid/in_stall with status, two data bytes and a time
// offset per transfer. Output channel: out_valid/out_stall, one message per
// transfer; out_last_of_run marks the final message caused by one input.
// An input item gives one message, none, or three (CC0, CC32 and a program
// change on the target channel, at time zero).
// An accepted item is held in the input register, is decoded into the result
// register once that register is free, and its first message is offered from
// there. A one-message item takes one output transfer, a three-message item
// three; the output port, one message per cycle while out_stall is low, sets
// the rate. An item that gives nothing offers no message. A stall on the
// output holds the result register and its payload; the input register
// then fills and in_stall rises. Configuration is written through
// cfg_wr_en/cfg_index/cfg_data; the user must write it only while idle, which
// the block itself does not enforce.
// Reset (rst_n low, synchronous) empties both registers, sets master channel
// 1, first key 21, target channel 1, clears the held keys, remap and shift,
// and clears every bank and program entry.
module midi_keyswitch_channel_router_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_status_byte,
  input  logic [6:0]  in_data_one,
  input  logic [6:0]  in_data_two,
  input  logic [15:0] in_time_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_status,
  output logic [6:0]  out_data_one,
  output logic [6:0]  out_data_two,
  output logic [15:0] out_time,
  output logic        out_last_of_run
);
  import mkcr_pkg::*;

  // configuration
  logic [4:0] master_r;
  logic [6:0] first_key_r;

  // routing state
  logic [4:0] target_r, target_nxt;
  logic [5:0] shift_r, shift_nxt;
  logic       remap_r, remap_nxt;
  logic       chan_held_r, chan_held_nxt;
  logic       bank_held_r, bank_held_nxt;
  logic       prog_held_r, prog_held_nxt;
  logic [6:0] bank_mem_r [CHANNELS];
  logic [6:0] prog_mem_r [CHANNELS];

  // input register
  logic        iv_r;
  logic [7:0]  st_r;
  logic [6:0]  d1_r, d2_r;
  logic [15:0] tm_r;

  // result register
  logic        jv_r;
  logic        triple_r;
  logic [1:0]  beat_r;
  logic [7:0]  one_st_r;
  logic [6:0]  one_d1_r, one_d2_r;
  logic [15:0] one_tm_r;
  logic [CH_W-1:0] tri_ch_r;
  logic [6:0]  tri_bank_r, tri_prog_r;

  logic adv, job_load, in_take, out_take;

  // decode
  logic [CH_W-1:0] ix;
  logic [3:0]  kind;
  logic        chan_msg, master_hit, drum_hit, is_note, press;
  logic [4:0]  chan;
  logic [8:0]  note9, fk9, rel9;
  logic [4:0]  sel;
  logic [7:0]  shifted;
  logic [6:0]  clamped;
  logic [6:0]  bank_cur, prog_cur;
  logic        bank_wr, prog_wr;
  logic [6:0]  bank_wval, prog_wval;
  logic        emit_one, emit_three;
  logic [7:0]  one_st;
  logic [6:0]  one_d1;

  assign out_valid = jv_r;
  assign out_take  = jv_r && !out_stall;
  assign adv       = !jv_r || (out_take && out_last_of_run);
  assign job_load  = iv_r && adv;
  assign in_stall  = iv_r && !adv;
  assign in_take   = in_valid && !in_stall;

  assign ix         = CH_W'(target_r - 5'd1);
  assign kind       = st_r[7:4];
  assign chan_msg   = st_r[7] && (st_r < STATUS_SYSTEM);
  assign chan       = {1'b0, st_r[3:0]} + 5'd1;
  assign master_hit = chan_msg && (chan == master_r);
  assign drum_hit   = chan_msg && remap_r && (chan == DRUM_CHANNEL);
  assign is_note    = (kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON);
  assign press      = (kind == KIND_NOTE_ON) && (d2_r != 7'd0);
  assign note9      = {2'b00, d1_r};
  assign fk9        = {2'b00, first_key_r};
  assign rel9       = note9 - fk9 - 9'd3;
  assign sel        = rel9[4:0] + 5'd1;
  assign shifted    = {1'b0, d1_r} + {2'b00, shift_r};
  assign clamped    = shifted[7] ? NOTE_MAX : shifted[6:0];
  assign bank_cur   = bank_mem_r[ix];
  assign prog_cur   = prog_mem_r[ix];

  always_comb begin
    target_nxt    = target_r;
    shift_nxt     = shift_r;
    remap_nxt     = remap_r;
    chan_held_nxt = chan_held_r;
    bank_held_nxt = bank_held_r;
    prog_held_nxt = prog_held_r;
    bank_wr       = 1'b0;
    prog_wr       = 1'b0;
    bank_wval     = bank_cur;
    prog_wval     = prog_cur;
    emit_one      = 1'b0;
    emit_three    = 1'b0;
    one_st        = st_r;
    one_d1        = d1_r;
    if (master_hit) begin
      if (!is_note) begin
        emit_one = 1'b1;
        one_st   = {kind, ix};
      end else if (note9 == fk9 + 9'd2) begin
        chan_held_nxt = press;
        if (press) begin
          if (bank_held_r && prog_held_r) begin
            emit_three = 1'b1;
          end else if (bank_held_r && prog_cur != NOTE_MAX) begin
            prog_wr    = 1'b1;
            prog_wval  = prog_cur + 7'd1;
            emit_three = 1'b1;
          end
        end
      end else if (note9 == fk9) begin
        prog_held_nxt = press;
        if (press) begin
          if (bank_held_r && chan_held_r) begin
            emit_three = 1'b1;
          end else if (bank_held_r && prog_cur != 7'd0) begin
            prog_wr    = 1'b1;
            prog_wval  = prog_cur - 7'd1;
            emit_three = 1'b1;
          end
        end
      end else if (note9 == fk9 + 9'd1) begin
        bank_held_nxt = press;
        if (press) begin
          if (chan_held_r && prog_held_r) begin
            emit_three = 1'b1;
          end else if (prog_held_r && prog_cur != 7'd0) begin
            prog_wr    = 1'b1;
            prog_wval  = prog_cur - 7'd1;
            emit_three = 1'b1;
          end else if (chan_held_r && prog_cur != NOTE_MAX) begin
            prog_wr    = 1'b1;
            prog_wval  = prog_cur + 7'd1;
            emit_three = 1'b1;
          end
        end
      end else if (chan_held_r && !bank_held_r && !prog_held_r &&
                   note9 >= fk9 + 9'd3 && note9 <= fk9 + 9'd21) begin
        if (press) begin
          priority if (sel == SEL_SHIFT_ONLY) begin
            remap_nxt = 1'b0; target_nxt = 5'd1; shift_nxt = SHIFT_UP;
          end else if (sel == SEL_REMAP_ONLY) begin
            remap_nxt = 1'b1; target_nxt = 5'd1; shift_nxt = 6'd0;
          end else if (sel == SEL_REMAP_SHIFT) begin
            remap_nxt = 1'b1; target_nxt = 5'd1; shift_nxt = SHIFT_UP;
          end else begin
            remap_nxt = 1'b0; target_nxt = sel; shift_nxt = 6'd0;
          end
        end
      end else if (!chan_held_r && bank_held_r && !prog_held_r &&
                   note9 >= fk9 + 9'd3 && note9 <= fk9 + 9'd18) begin
        if (press) begin
          bank_wr    = 1'b1;
          bank_wval  = rel9[6:0];
          prog_wr    = 1'b1;
          prog_wval  = 7'd0;
          emit_three = 1'b1;
        end
      end else if (!bank_held_r && prog_held_r &&
                   note9 >= fk9 + 9'd3 && note9 <= fk9 + 9'd66) begin
        if (press) begin
          prog_wr    = 1'b1;
          prog_wval  = rel9[6:0] + (chan_held_r ? PROG_UPPER : 7'd0);
          emit_three = 1'b1;
        end
      end else begin
        emit_one = 1'b1;
        one_st   = {kind, ix};
        one_d1   = clamped;
      end
    end else if (drum_hit) begin
      emit_one = 1'b1;
      one_st   = {kind, 4'd0};
      one_d1   = is_note ? clamped : d1_r;
    end else begin
      emit_one = 1'b1;
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r    <= MASTER_RST;
      first_key_r <= FIRST_KEY_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MASTER_CHANNEL: master_r    <= cfg_data[4:0];
        REG_FIRST_KEY:      first_key_r <= cfg_data;
        default:            ;
      endcase
    end
  end

  // routing state, updated as an item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RST;
      shift_r     <= 6'd0;
      remap_r     <= 1'b0;
      chan_held_r <= 1'b0;
      bank_held_r <= 1'b0;
      prog_held_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        bank_mem_r[i] <= 7'd0;
        prog_mem_r[i] <= 7'd0;
      end
    end else if (job_load) begin
      target_r    <= target_nxt;
      shift_r     <= shift_nxt;
      remap_r     <= remap_nxt;
      chan_held_r <= chan_held_nxt;
      bank_held_r <= bank_held_nxt;
      prog_held_r <= prog_held_nxt;
      if (bank_wr) begin
        bank_mem_r[ix] <= bank_wval;
      end
      if (prog_wr) begin
        prog_mem_r[ix] <= prog_wval;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_take) begin
      iv_r <= 1'b1;
    end else if (job_load) begin
      iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      st_r <= in_status_byte;
      d1_r <= in_data_one;
      d2_r <= in_data_two;
      tm_r <= in_time_offset;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jv_r   <= 1'b0;
      beat_r <= 2'd0;
    end else if (job_load) begin
      jv_r   <= emit_one || emit_three;
      beat_r <= 2'd0;
    end else if (out_take) begin
      if (out_last_of_run) begin
        jv_r <= 1'b0;
      end
      beat_r <= beat_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      triple_r   <= emit_three;
      one_st_r   <= one_st;
      one_d1_r   <= one_d1;
      one_d2_r   <= d2_r;
      one_tm_r   <= tm_r;
      tri_ch_r   <= ix;
      tri_bank_r <= bank_wval;
      tri_prog_r <= prog_wval;
    end
  end

  // output mux over the beats of a bank and program run
  always_comb begin
    out_status      = one_st_r;
    out_data_one    = one_d1_r;
    out_data_two    = one_d2_r;
    out_time        = one_tm_r;
    out_last_of_run = 1'b1;
    if (triple_r) begin
      out_time = 16'd0;
      unique case (beat_r)
        2'd0: begin
          out_status      = {KIND_CTRL, tri_ch_r};
          out_data_one    = CC_BANK_MSB;
          out_data_two    = tri_bank_r;
          out_last_of_run = 1'b0;
        end
        2'd1: begin
          out_status      = {KIND_CTRL, tri_ch_r};
          out_data_one    = CC_BANK_LSB;
          out_data_two    = tri_bank_r;
          out_last_of_run = 1'b0;
        end
        default: begin
          out_status      = {KIND_PROG, tri_ch_r};
          out_data_one    = tri_prog_r;
          out_data_two    = 7'd0;
          out_last_of_run = 1'b1;
        end
      endcase
    end
  end

endmodule
